/* hdl/lru_write_back_block_cache_tags_macros.svh */
// Assertion helpers for the cache tags RTL module.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_TAGS_MACROS_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_TAGS_MACROS_SVH

// Implication checked every cycle outside reset.
`define LWB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define LWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lwbc_pkg.sv */
`default_nettype none
package lwbc_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ADDR_BITS = 32;
    localparam int TICK_W    = 64;
    localparam int DEV_W     = 33;

    localparam logic [2:0] K_READ   = 3'd0;
    localparam logic [2:0] K_WRITE  = 3'd1;
    localparam logic [2:0] K_FLUSH  = 3'd2;
    localparam logic [2:0] K_FALL   = 3'd3;
    localparam logic [2:0] K_CLEAR  = 3'd4;
    localparam logic [2:0] K_PROBE  = 3'd5;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [TICK_W-1:0]    t_tick;

    // Memory write request for one slot entry
    typedef struct packed {
        logic  en;
        t_slot idx;
        t_addr tag;
        t_tick last_use;
    } t_mem_wr;
endpackage
`default_nettype wire

/* hdl/lwbc_slot_mem.sv */
`default_nettype none
// Slot tag and last-use store, one write and one registered read a cycle.
module lwbc_slot_mem (
    input  wire                    i_clk,
    input  lwbc_pkg::t_slot        i_rd_idx,
    output lwbc_pkg::t_addr        o_rd_tag,
    output lwbc_pkg::t_tick        o_rd_last_use,
    input  lwbc_pkg::t_mem_wr      i_wr
);
    import lwbc_pkg::*;

    t_addr r_tag [SLOTS];
    t_tick r_use [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tag[i_wr.idx] <= i_wr.tag;
            r_use[i_wr.idx] <= i_wr.last_use;
        end
        o_rd_tag      <= r_tag[i_rd_idx];
        o_rd_last_use <= r_use[i_rd_idx];
    end
endmodule
`default_nettype wire

/* hdl/lru_write_back_block_cache_tags.sv */
// Lookup: a read, write, flush block or probe command scans all 16 slots through the
//   memory's registered read port, then gives its word from the decide state.
//   An address outside the device or an unused kind skips the scan and goes to decide.
// Flush all / clear read then handle each slot, a word per dirty slot, until the last dirty one.
// One command at a time: o_ready only in idle; output waits stall the decide and sweep states.
// Reset: valid/dirty bits, counts and use tick cleared; tags undefined; device_blocks 2^32.
`default_nettype none
module lru_write_back_block_cache_tags (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [32:0]                  i_cfg_wdata,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire [2:0]                   i_kind,
    input  wire [31:0]                  i_block_address,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic                        o_status,
    output logic                        o_hit,
    output logic [3:0]                  o_slot,
    output logic                        o_slot_dirty,
    output logic                        o_fetch,
    output logic                        o_writeback_valid,
    output logic [31:0]                 o_writeback_address,
    output logic [3:0]                  o_writeback_slot,
    output logic [4:0]                  o_valid_slots,
    output logic [4:0]                  o_dirty_slots,
    output logic                        o_last
);
    import lwbc_pkg::*;
    `include "lru_write_back_block_cache_tags_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_FSCN = 3'd4;

    logic [2:0]        r_state;
    logic [DEV_W-1:0]  r_dev;
    logic [SLOTS-1:0]  r_vld, r_drt;
    t_cnt              r_vcnt, r_dcnt;
    t_tick             r_tick;
    logic [2:0]        r_kind;
    t_addr             r_addr;
    logic [SLOT_W:0]   r_ctr;       // issue counter, one past depth
    logic              r_rv;        // memory read in flight
    t_slot             r_ridx;
    logic              r_found;
    t_slot             r_hidx;
    logic              r_vsel;
    t_slot             r_vidx;
    t_tick             r_vuse;
    t_addr             r_vtag;
    logic              r_last_seen; // a flush word has been emitted before

    t_addr     m_tag;
    t_tick     m_use;
    t_mem_wr   r_wr;
    t_slot     w_rd_idx;

    lwbc_slot_mem u_mem (
        .i_clk(i_clk), .i_rd_idx(w_rd_idx), .o_rd_tag(m_tag),
        .o_rd_last_use(m_use), .i_wr(r_wr)
    );

    assign w_rd_idx = r_ctr[SLOT_W-1:0];
    assign o_ready  = (r_state == S_IDLE);

    logic w_out_free;
    assign w_out_free = !o_valid || i_ready;

    // first free slot (combinational priority over valid bits)
    logic  w_has_free;
    t_slot w_free;
    always_comb begin
        w_has_free = 1'b0;
        w_free     = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_vld[i]) begin
                w_has_free = 1'b1;
                w_free     = t_slot'(i);
            end
        end
    end

    // dirty slots above the read index, for last marking
    logic w_more_dirty;
    always_comb begin
        w_more_dirty = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (t_slot'(i) > r_ridx && r_vld[i] && r_drt[i]) w_more_dirty = 1'b1;
        end
    end

    logic w_emit, w_fl_word, w_load, w_rw_go;
    assign w_emit    = r_vld[r_ridx] && r_drt[r_ridx];
    // nothing dirty at all still gives one empty word
    assign w_fl_word = w_emit || (!w_more_dirty && !r_last_seen);
    assign w_load    = w_out_free && ((r_state == S_DEC) ||
                                      (r_state == S_FSCN && r_rv && w_fl_word));
    assign w_rw_go   = (r_state == S_DEC) && w_out_free &&
                       (r_kind inside {K_READ, K_WRITE}) && ({1'b0, r_addr} < r_dev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dev   <= {1'b1, 32'd0};
            r_vld   <= '0;
            r_drt   <= '0;
            r_vcnt  <= '0;
            r_dcnt  <= '0;
            r_tick  <= '0;
            o_valid <= 1'b0;
            r_ctr   <= '0;
            r_rv    <= 1'b0;
            r_wr.en <= 1'b0;
        end else begin
            if (i_cfg_we) r_dev <= i_cfg_wdata;
            o_valid <= w_load || (o_valid && !i_ready);
            r_wr.en <= w_rw_go;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_addr  <= i_block_address;
                        r_ctr   <= '0;
                        r_rv    <= 1'b0;
                        r_found <= 1'b0;
                        r_vsel  <= 1'b0;
                        r_last_seen <= 1'b0;
                        if (i_kind == K_FALL || i_kind == K_CLEAR) r_state <= S_FSCN;
                        else if (i_kind > K_PROBE ||
                                 {1'b0, i_block_address} >= r_dev) r_state <= S_DEC;
                        else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ctr < (SLOT_W+1)'(SLOTS)) r_ctr <= r_ctr + 1'b1;
                    r_rv   <= (r_ctr < (SLOT_W+1)'(SLOTS));
                    r_ridx <= w_rd_idx;
                    if (r_rv && r_vld[r_ridx]) begin
                        if (!r_found && m_tag == r_addr) begin
                            r_found <= 1'b1;
                            r_hidx  <= r_ridx;
                        end
                        if (!r_vsel || m_use < r_vuse) begin
                            r_vsel <= 1'b1;
                            r_vidx <= r_ridx;
                            r_vuse <= m_use;
                            r_vtag <= m_tag;
                        end
                    end
                    if (r_rv && r_ridx == t_slot'(SLOTS - 1)) r_state <= S_DEC;
                end
                S_DEC: begin
                    if (w_out_free) begin : dec
                        t_slot s, sl, ws;
                        logic  wd, st, ht, sd, fe, wv;
                        t_cnt  vc, dc;
                        t_addr wa;
                        s  = r_found ? r_hidx : (w_has_free ? w_free : r_vidx);
                        vc = r_vcnt;
                        dc = r_dcnt;
                        wd = 1'b0;
                        st = 1'b0; ht = 1'b0; sl = '0; sd = 1'b0; fe = 1'b0;
                        wv = 1'b0; wa = '0; ws = '0;
                        if (r_kind > K_PROBE) begin
                            // unused kinds leave the state alone
                        end else if ({1'b0, r_addr} >= r_dev) begin
                            st = 1'b1;
                        end else if (r_kind == K_PROBE) begin
                            ht = r_found;
                            sl = r_found ? r_hidx : '0;
                            sd = r_found && r_drt[r_hidx];
                        end else if (r_kind == K_FLUSH) begin
                            ht = r_found;
                            sl = r_found ? r_hidx : '0;
                            if (r_found && r_drt[r_hidx]) begin
                                wv = 1'b1;
                                wa = r_addr;
                                ws = r_hidx;
                                dc = dc - 1'b1;
                                r_drt[r_hidx] <= 1'b0;
                            end
                        end else begin
                            wd = r_found && r_drt[s];
                            if (!r_found) begin
                                if (w_has_free) vc = vc + 1'b1;
                                else if (r_drt[s]) begin
                                    wv = 1'b1;
                                    wa = r_vtag;
                                    ws = s;
                                    dc = dc - 1'b1;
                                end
                                fe = (r_kind == K_READ);
                            end
                            if (r_kind == K_WRITE && !wd) dc = dc + 1'b1;
                            ht = r_found;
                            sl = s;
                            r_vld[s] <= 1'b1;
                            r_drt[s] <= (r_kind == K_WRITE) ? 1'b1 : wd;
                            r_tick <= r_tick + 1'b1;
                            r_wr.idx <= s;
                            r_wr.tag <= r_addr;
                            r_wr.last_use <= r_tick + 1'b1;
                        end
                        r_vcnt <= vc;
                        r_dcnt <= dc;
                        o_status <= st; o_hit <= ht; o_slot <= sl;
                        o_slot_dirty <= sd; o_fetch <= fe;
                        o_writeback_valid <= wv; o_writeback_address <= wa;
                        o_writeback_slot <= ws; o_last <= 1'b1;
                        o_valid_slots <= vc; o_dirty_slots <= dc;
                        r_state <= S_IDLE;
                    end
                end
                S_FSCN: begin
                    // read each slot's tag, emit dirty ones in order; the read index
                    // holds until the slot is done so the tag stays on the port
                    if (!r_rv) begin
                        r_rv   <= 1'b1;
                        r_ridx <= w_rd_idx;
                    end else if (w_out_free) begin
                        r_rv  <= 1'b0;
                        r_ctr <= r_ctr + 1'b1;
                        if (w_emit) r_last_seen <= 1'b1;
                        if (w_fl_word) begin
                            o_status <= 1'b0; o_hit <= 1'b0; o_slot_dirty <= 1'b0;
                            o_fetch <= 1'b0;
                            o_writeback_valid   <= w_emit;
                            o_writeback_address <= w_emit ? m_tag : '0;
                            o_writeback_slot    <= w_emit ? r_ridx : '0;
                            o_slot              <= w_emit ? r_ridx : '0;
                            o_last              <= !w_more_dirty;
                            o_dirty_slots       <= '0;
                            o_valid_slots       <= (r_kind == K_CLEAR) ? '0 : r_vcnt;
                        end
                        if (!w_more_dirty) begin
                            r_state <= S_IDLE;
                            r_dcnt  <= '0;
                            r_drt   <= '0;
                            if (r_kind == K_CLEAR) begin
                                r_vld  <= '0;
                                r_vcnt <= '0;
                                r_tick <= '0;
                            end
                        end else if (w_emit) begin
                            r_drt[r_ridx] <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LWB_ASSERT_IMP(a_ready_idle, o_ready, r_state == S_IDLE, "ready outside idle")
    `LWB_ASSERT_IMP(a_cnt_range, 1'b1, r_vcnt <= t_cnt'(SLOTS) && r_dcnt <= r_vcnt,
                    "counter out of range")
    `LWB_ASSERT_NEXT(a_accept_busy, i_valid && o_ready, !o_ready, "accept did not leave idle")
endmodule
`default_nettype wire

/* tb/tb_lru_write_back_block_cache_tags.sv */
`default_nettype none
module tb_lru_write_back_block_cache_tags;
    timeunit 1ns;
    timeprecision 1ps;
    import lwbc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [3:0]  slot;
        logic        sdirty;
        logic        fetch;
        logic        wbv;
        logic [31:0] wba;
        logic [3:0]  wbs;
        logic [4:0]  vc;
        logic [4:0]  dc;
        logic        lst;
    } t_cache_word;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] addr;
        bit          typed;
        t_cache_word want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [32:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [31:0] i_block_address = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_status, o_hit, o_slot_dirty, o_fetch, o_writeback_valid, o_last;
    logic [3:0]  o_slot, o_writeback_slot;
    logic [31:0] o_writeback_address;
    logic [4:0]  o_valid_slots, o_dirty_slots;

    lru_write_back_block_cache_tags u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid, .o_ready, .i_kind, .i_block_address,
        .o_valid, .i_ready, .o_status, .o_hit, .o_slot, .o_slot_dirty, .o_fetch,
        .o_writeback_valid, .o_writeback_address, .o_writeback_slot,
        .o_valid_slots, .o_dirty_slots, .o_last
    );

    // shadow copy of the tag store
    logic        sh_valid [SLOTS];
    logic        sh_dirty [SLOTS];
    logic [31:0] sh_tag   [SLOTS];
    logic [63:0] sh_used  [SLOTS];
    logic [63:0] sh_tick;
    logic [4:0]  sh_vc, sh_dc;
    logic [32:0] sh_dev;

    t_cache_word pending_words[$];
    int          errors = 0;
    int unsigned cycles = 0;
    int unsigned rx_idle = 0;
    bit          hold_req = 0;
    int unsigned hold_left = 0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_words.size());
            $display("** lru_write_back_block_cache_tags: FAILED **");
            $finish;
        end
    end

    task automatic report(input string fld, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, fld, got, want);
        errors++;
    endtask

    task automatic check_word(input t_cache_word got);
        t_cache_word w;
        if (pending_words.size() == 0) begin
            report("unexpected word", 32'(got.slot), 32'd0);
            return;
        end
        w = pending_words.pop_front();
        if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
        if (got.hit    !== w.hit)    report("hit", 32'(got.hit), 32'(w.hit));
        if (got.slot   !== w.slot)   report("slot", 32'(got.slot), 32'(w.slot));
        if (got.sdirty !== w.sdirty) report("slot_dirty", 32'(got.sdirty), 32'(w.sdirty));
        if (got.fetch  !== w.fetch)  report("fetch", 32'(got.fetch), 32'(w.fetch));
        if (got.wbv    !== w.wbv)    report("writeback_valid", 32'(got.wbv), 32'(w.wbv));
        if (got.wba    !== w.wba)    report("writeback_address", got.wba, w.wba);
        if (got.wbs    !== w.wbs)    report("writeback_slot", 32'(got.wbs), 32'(w.wbs));
        if (got.vc     !== w.vc)     report("valid_slots", 32'(got.vc), 32'(w.vc));
        if (got.dc     !== w.dc)     report("dirty_slots", 32'(got.dc), 32'(w.dc));
        if (got.lst    !== w.lst)    report("last", 32'(got.lst), 32'(w.lst));
    endtask

    // result side: check, then choose ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_word({o_status, o_hit, o_slot, o_slot_dirty, o_fetch, o_writeback_valid,
                        o_writeback_address, o_writeback_slot, o_valid_slots,
                        o_dirty_slots, o_last});
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic sweep_dirty(input bit wipe);
        t_cache_word ws[$];
        t_cache_word w;
        for (int i = 0; i < SLOTS; i++) begin
            if (sh_valid[i] && sh_dirty[i]) begin
                w = '0;
                w.slot = 4'(i);
                w.wbv = 1'b1;
                w.wba = sh_tag[i];
                w.wbs = 4'(i);
                ws.push_back(w);
                sh_dirty[i] = 1'b0;
            end
        end
        sh_dc = '0;
        if (wipe) begin
            for (int i = 0; i < SLOTS; i++) begin
                sh_valid[i] = 1'b0;
                sh_used[i] = '0;
            end
            sh_tick = '0;
            sh_vc = '0;
        end
        if (ws.size() == 0) ws.push_back('0);
        ws[ws.size()-1].lst = 1'b1;
        foreach (ws[i]) begin
            ws[i].vc = sh_vc;
            ws[i].dc = sh_dc;
            pending_words.push_back(ws[i]);
        end
    endtask

    task automatic predict_command(input logic [2:0] kind, input logic [31:0] addr);
        t_cache_word w;
        int s;
        w = '0;
        w.lst = 1'b1;
        s = -1;
        if (kind == K_FALL || kind == K_CLEAR) begin
            sweep_dirty(kind == K_CLEAR);
            return;
        end
        if (kind > K_PROBE) begin
            // spare kinds: nothing happens
        end else if ({1'b0, addr} >= sh_dev) begin
            w.status = 1'b1;
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && sh_valid[i] && sh_tag[i] == addr) s = i;
            if (kind == K_PROBE) begin
                if (s >= 0) begin
                    w.hit = 1'b1;
                    w.slot = 4'(s);
                    w.sdirty = sh_dirty[s];
                end
            end else if (kind == K_FLUSH) begin
                if (s >= 0) begin
                    w.hit = 1'b1;
                    w.slot = 4'(s);
                    if (sh_dirty[s]) begin
                        w.wbv = 1'b1;
                        w.wba = sh_tag[s];
                        w.wbs = 4'(s);
                        sh_dirty[s] = 1'b0;
                        sh_dc--;
                    end
                end
            end else begin
                if (s >= 0) begin
                    w.hit = 1'b1;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && !sh_valid[i]) s = i;
                    if (s < 0) begin
                        s = 0;
                        for (int i = 1; i < SLOTS; i++)
                            if (sh_used[i] < sh_used[s]) s = i;
                        if (sh_dirty[s]) begin
                            w.wbv = 1'b1;
                            w.wba = sh_tag[s];
                            w.wbs = 4'(s);
                            sh_dc--;
                        end
                    end else begin
                        sh_vc++;
                    end
                    sh_valid[s] = 1'b1;
                    sh_dirty[s] = 1'b0;
                    sh_tag[s] = addr;
                    w.fetch = (kind == K_READ);
                end
                sh_tick++;
                sh_used[s] = sh_tick;
                if (kind == K_WRITE && !sh_dirty[s]) begin
                    sh_dirty[s] = 1'b1;
                    sh_dc++;
                end
                w.slot = 4'(s);
            end
        end
        w.vc = sh_vc;
        w.dc = sh_dc;
        pending_words.push_back(w);
    endtask

    // send lowers valid only while idling, so back-to-back commands keep it high
    task automatic send(input logic [2:0] kind, input logic [31:0] addr,
                        input int unsigned tx_idle);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_block_address <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_device_blocks(input logic [32:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_dev = v;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [32:0] dev, input int unsigned tx_idle,
                                input int unsigned rxi, input int unsigned n,
                                input bit squeeze);
        logic [2:0]  kind;
        logic [31:0] addr;
        int unsigned r;
        int unsigned k;
        set_device_blocks(dev);
        rx_idle = rxi;
        if (squeeze) hold_req = 1;
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40)      kind = K_READ;
            else if (r < 72) kind = K_WRITE;
            else if (r < 80) kind = K_FLUSH;
            else if (r < 88) kind = K_PROBE;
            else if (r < 92) kind = K_FALL;
            else if (r < 95) kind = K_CLEAR;
            else             kind = ($urandom_range(1) != 0) ? K_SPARE7 : K_SPARE6;
            r = $urandom_range(99);
            k = $urandom_range(11);
            if (r < 75)      addr = ($urandom_range(1) != 0) ? 32'(k) : 32'hFFFF_FFFF - k;
            else if (r < 85) addr = $urandom;
            else if (r < 95) addr = ($urandom_range(1) != 0) ? sh_dev[31:0] : sh_dev[31:0] - 1;
            else             addr = 32'hFFFF_FFFF;
            send(kind, addr, tx_idle);
            predict_command(kind, addr);
            // sender stops until the block has emptied
            if (squeeze && i == n / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_words.size() != 0) @(posedge i_clk);
            end
        end
        drain();
    endtask

    t_stim_row rows[$];

    function automatic t_stim_row row(input logic [2:0] kind, input logic [31:0] addr);
        t_stim_row r;
        r.kind = kind;
        r.addr = addr;
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    initial begin
        t_stim_row r;
        for (int i = 0; i < SLOTS; i++) begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_tag[i] = '0;
            sh_used[i] = '0;
        end
        sh_tick = '0;
        sh_vc = '0;
        sh_dc = '0;
        sh_dev = 33'h1_0000_0000;

        // first read after reset: slot 0, fetch
        r = row(K_READ, 32'h0);
        r.typed = 1; r.want.fetch = 1; r.want.vc = 1; r.want.lst = 1;
        rows.push_back(r);
        r = row(K_WRITE, 32'hFFFF_FFFF);
        r.typed = 1; r.want.slot = 1; r.want.vc = 2; r.want.dc = 1; r.want.lst = 1;
        rows.push_back(r);
        r = row(K_SPARE6, 32'h0);
        r.typed = 1; r.want.vc = 2; r.want.dc = 1; r.want.lst = 1;
        rows.push_back(r);
        r.kind = K_SPARE7; r.addr = 32'hFFFF_FFFF;
        rows.push_back(r);
        rows.push_back(row(K_PROBE, 32'hFFFF_FFFF));
        rows.push_back(row(K_READ, 32'hFFFF_FFFF));
        rows.push_back(row(K_WRITE, 32'h0));
        rows.push_back(row(K_FLUSH, 32'h0));
        rows.push_back(row(K_FLUSH, 32'h5));
        rows.push_back(row(K_PROBE, 32'h0));
        rows.push_back(row(K_FALL, 32'h0));
        // nothing left to flush
        r = row(K_FALL, 32'h0);
        r.typed = 1; r.want.vc = 2; r.want.lst = 1;
        rows.push_back(r);
        for (int i = 2; i < 8; i++) rows.push_back(row(K_WRITE, 32'(i)));
        rows.push_back(row(K_READ, 32'hAAAA_5555));
        rows.push_back(row(K_WRITE, 32'h5555_AAAA));
        rows.push_back(row(K_CLEAR, 32'h0));
        rows.push_back(row(K_PROBE, 32'h0));
        r = row(K_CLEAR, 32'hFFFF_FFFF);
        r.typed = 1; r.want.lst = 1;
        rows.push_back(r);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send(rows[i].kind, rows[i].addr, 0);
            if (rows[i].typed) begin
                pending_words.push_back(rows[i].want);
                predict_command(rows[i].kind, rows[i].addr);
                void'(pending_words.pop_back());
            end else begin
                predict_command(rows[i].kind, rows[i].addr);
            end
        end
        drain();

        random_phase(33'hFFFF_FFFF, 22, 85, 90, 0);
        random_phase(33'h1, 85, 22, 90, 0);
        random_phase(33'd40, 0, 0, 90, 0);
        random_phase(33'h1_0000_0000, 0, 0, 100, 1);

        if (errors == 0) begin
            $display("** lru_write_back_block_cache_tags: PASSED **");
        end else begin
            $display("** lru_write_back_block_cache_tags: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/lwbc_pkg.sv
hdl/lwbc_slot_mem.sv
hdl/lru_write_back_block_cache_tags.sv
tb/tb_lru_write_back_block_cache_tags.sv
